>>> hw/rtl/sha1bsh_pkg.sv
`default_nettype none

package sha1bsh_pkg;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	localparam work_t IV = '{
		a: 32'h67452301,
		b: 32'hefcdab89,
		c: 32'h98badcfe,
		d: 32'h10325476,
		e: 32'hc3d2e1f0
	};

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam int unsigned ROUNDS    = 80;
	localparam int unsigned RND_W     = 7;
	localparam int unsigned LEN_POS   = 56;
	localparam int unsigned NUM_WORDS = 5;

endpackage

`default_nettype wire

>>> hw/rtl/sha1bsh_round.sv
`default_nettype none

// One SHA-1 round: a..e advance by one step using schedule word w.
module sha1bsh_round (
	input  wire sha1bsh_pkg::work_t       cur,
	input  wire logic [31:0]              w,
	input  wire logic [sha1bsh_pkg::RND_W-1:0] rnd,
	output sha1bsh_pkg::work_t            nxt
);

	logic [31:0] f;
	logic [31:0] k;
	logic [31:0] t;

	always_comb begin
		case (rnd) inside
			[7'd0:7'd19]: begin
				f = (cur.b & cur.c) | (~cur.b & cur.d);
				k = sha1bsh_pkg::K0;
			end
			[7'd20:7'd39]: begin
				f = cur.b ^ cur.c ^ cur.d;
				k = sha1bsh_pkg::K1;
			end
			[7'd40:7'd59]: begin
				f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
				k = sha1bsh_pkg::K2;
			end
			default: begin
				f = cur.b ^ cur.c ^ cur.d;
				k = sha1bsh_pkg::K3;
			end
		endcase
	end

	assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + w + k;

	always_comb begin
		nxt.a = t;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

`default_nettype wire

>>> hw/rtl/sha1_byte_stream_hasher.sv
// Takes one data byte per cycle while idle; every 64th byte starts a compression of 80
// rounds through the single round unit and a chain-add step, with msg_stall held high.
// End of message feeds pad and length bytes one per cycle with one or two compressions,
// then presents h0..h4 as five output beats, one per cycle while dig_stall is low.
// Reset (arst_n low, asynchronous) clears control state, byte count and byte slot and
// loads the chain with the SHA-1 initial vector.
`default_nettype none

module sha1_byte_stream_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        msg_valid,
	output logic             msg_stall,
	input  wire logic        kind,
	input  wire logic [7:0]  data_byte,
	output logic             dig_valid,
	input  wire logic        dig_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	sha1bsh_pkg::state_t state_q, state_d;

	logic [511:0] blk_q;
	sha1bsh_pkg::work_t work_q, chain_q, round_nxt;
	logic [60:0] byte_cnt_q;
	logic [5:0]  pos_q;
	logic [sha1bsh_pkg::RND_W-1:0] rnd_q;
	logic [2:0]  idx_q;
	logic        pad_q, sent80_q, tail_q, fin_q;

	logic        data_acc, end_acc, push, dig_acc, last_rnd;
	logic [7:0]  push_byte, len_byte;
	logic [63:0] bit_len;
	logic [31:0] w_cur, w_new, w_mix;

	assign data_acc = (state_q == sha1bsh_pkg::ST_IDLE) && msg_valid && !kind;
	assign end_acc  = (state_q == sha1bsh_pkg::ST_IDLE) && msg_valid && kind;
	assign push     = data_acc || (state_q == sha1bsh_pkg::ST_PAD);
	assign dig_acc  = dig_valid && !dig_stall;
	assign last_rnd = rnd_q == sha1bsh_pkg::RND_W'(sha1bsh_pkg::ROUNDS - 1);

	// length goes out big-endian in slots 56..63
	assign bit_len  = {byte_cnt_q, 3'b000};
	assign len_byte = 8'(bit_len >> {~pos_q[2:0], 3'b000});

	always_comb begin
		if (state_q != sha1bsh_pkg::ST_PAD)
			push_byte = data_byte;
		else if (!sent80_q)
			push_byte = sha1bsh_pkg::PAD_BYTE;
		else if (tail_q || pos_q < 6'(sha1bsh_pkg::LEN_POS))
			push_byte = 8'h00;
		else
			push_byte = len_byte;
	end

	// schedule window: top word is w[t]; the new word w[t+16] taps w[t+13], w[t+8], w[t+2], w[t]
	assign w_cur = blk_q[511:480];
	assign w_mix = blk_q[511:480] ^ blk_q[447:416] ^ blk_q[255:224] ^ blk_q[95:64];
	assign w_new = {w_mix[30:0], w_mix[31]};

	sha1bsh_round u_round (
		.cur (work_q),
		.w   (w_cur),
		.rnd (rnd_q),
		.nxt (round_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sha1bsh_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		msg_stall = 1'b1;
		dig_valid = 1'b0;
		case (state_q)
			sha1bsh_pkg::ST_IDLE: begin
				msg_stall = 1'b0;
				if (end_acc)
					state_d = sha1bsh_pkg::ST_PAD;
				else if (data_acc && pos_q == 6'h3f)
					state_d = sha1bsh_pkg::ST_ROUND;
			end
			sha1bsh_pkg::ST_PAD: begin
				if (pos_q == 6'h3f)
					state_d = sha1bsh_pkg::ST_ROUND;
			end
			sha1bsh_pkg::ST_ROUND: begin
				if (last_rnd)
					state_d = sha1bsh_pkg::ST_FOLD;
			end
			sha1bsh_pkg::ST_FOLD: begin
				if (!pad_q)
					state_d = sha1bsh_pkg::ST_IDLE;
				else if (fin_q)
					state_d = sha1bsh_pkg::ST_EMIT;
				else
					state_d = sha1bsh_pkg::ST_PAD;
			end
			sha1bsh_pkg::ST_EMIT: begin
				dig_valid = 1'b1;
				if (!dig_stall && idx_q == 3'(sha1bsh_pkg::NUM_WORDS - 1))
					state_d = sha1bsh_pkg::ST_IDLE;
			end
			default: begin
				state_d = sha1bsh_pkg::ST_IDLE;
			end
		endcase
	end

	// block window and working words carry no reset
	always_ff @(posedge clk) begin
		if (push)
			blk_q <= {blk_q[503:0], push_byte};
		else if (state_q == sha1bsh_pkg::ST_ROUND)
			blk_q <= {blk_q[479:0], w_new};

		if (push && pos_q == 6'h3f)
			work_q <= chain_q;
		else if (state_q == sha1bsh_pkg::ST_ROUND)
			work_q <= round_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q    <= sha1bsh_pkg::IV;
			byte_cnt_q <= '0;
			pos_q      <= '0;
			rnd_q      <= '0;
			idx_q      <= '0;
			pad_q      <= 1'b0;
			sent80_q   <= 1'b0;
			tail_q     <= 1'b0;
			fin_q      <= 1'b0;
		end else begin
			if (data_acc)
				byte_cnt_q <= byte_cnt_q + 61'd1;
			if (push)
				pos_q <= pos_q + 6'd1;
			if (end_acc) begin
				pad_q    <= 1'b1;
				sent80_q <= 1'b0;
				tail_q   <= 1'b0;
				fin_q    <= 1'b0;
			end
			if (state_q == sha1bsh_pkg::ST_PAD) begin
				sent80_q <= 1'b1;
				if (pos_q == 6'h3f) begin
					// a block ending in zeros or in the 0x80 pad byte is followed by the length block
					fin_q  <= sent80_q && !tail_q;
					tail_q <= 1'b0;
				end else if (!sent80_q) begin
					tail_q <= pos_q >= 6'(sha1bsh_pkg::LEN_POS);
				end
			end
			if (push && pos_q == 6'h3f)
				rnd_q <= '0;
			else if (state_q == sha1bsh_pkg::ST_ROUND)
				rnd_q <= last_rnd ? '0 : rnd_q + 1'b1;
			if (state_q == sha1bsh_pkg::ST_FOLD) begin
				chain_q.a <= chain_q.a + work_q.a;
				chain_q.b <= chain_q.b + work_q.b;
				chain_q.c <= chain_q.c + work_q.c;
				chain_q.d <= chain_q.d + work_q.d;
				chain_q.e <= chain_q.e + work_q.e;
			end
			if (dig_acc) begin
				if (idx_q == 3'(sha1bsh_pkg::NUM_WORDS - 1)) begin
					chain_q    <= sha1bsh_pkg::IV;
					byte_cnt_q <= '0;
					idx_q      <= '0;
					pad_q      <= 1'b0;
					fin_q      <= 1'b0;
				end else begin
					chain_q <= {chain_q.b, chain_q.c, chain_q.d, chain_q.e, chain_q.a};
					idx_q   <= idx_q + 3'd1;
				end
			end
		end
	end

	assign digest_word = chain_q.a;
	assign word_index  = idx_q;
	assign last_word   = idx_q == 3'(sha1bsh_pkg::NUM_WORDS - 1);

	a_no_input_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> msg_stall)
		else $error("input taken while digest beats pending");

	a_round_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q < sha1bsh_pkg::RND_W'(sha1bsh_pkg::ROUNDS))
		else $error("round counter out of range");

	a_round_on_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1bsh_pkg::ST_ROUND) |-> (pos_q == 6'd0))
		else $error("compression running on partial block");

	a_chain_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_acc && last_word) |=> (chain_q == sha1bsh_pkg::IV && byte_cnt_q == '0))
		else $error("chain not reloaded after digest");

endmodule

`default_nettype wire
